// File: hw/rtl/ttps_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the transposition table probe/store block.
package ttps_pkg;

   localparam int KEY_W    = 64;
   localparam int SCORE_W  = 16;
   localparam int DEPTH_W  = 7;
   localparam int PLY_W    = 7;
   localparam int DANGER_W = 8;
   localparam int MOVE_W   = 25;
   localparam int MOVE_LO_W = 20;
   localparam int MASK_W   = 16;

   localparam int REQ_DATA_W = 176;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 4;

   // Scores whose magnitude is at or beyond MATE_NEAR (MATE_SCORE - 100) are treated as mate scores.
   localparam int MATE_SCORE = 30000;
   localparam logic [SCORE_W:0] MATE_NEAR = (SCORE_W + 1)'(MATE_SCORE - 100);

   typedef enum logic [1:0] {
      MODE_LOOKUP = 2'd0,
      MODE_REFUTE = 2'd1,
      MODE_BEST   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_EMPTY = 2'd0,
      KIND_EXACT = 2'd1,
      KIND_UPPER = 2'd2,
      KIND_LOWER = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STAT_MISS   = 3'd0,
      STAT_EXACT  = 3'd1,
      STAT_UPPER  = 3'd2,
      STAT_LOWER  = 3'd3,
      STAT_STORED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_READ,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [SCORE_W-1:0]  score;
      logic [DEPTH_W-1:0]  depth;
      kind_type            kind;
      logic [DANGER_W-1:0] danger;
      logic [MOVE_W-1:0]   move;
   } table_entry_type;

   localparam int ENTRY_W = $bits(table_entry_type);

   typedef struct packed {
      logic [1:0]          mode;
      logic [KEY_W-1:0]    key;
      logic [PLY_W-1:0]    ply;
      logic [DEPTH_W-1:0]  depth;
      logic [SCORE_W-1:0]  alpha;
      logic [SCORE_W-1:0]  beta;
      logic [SCORE_W-1:0]  init_alpha;
      logic [SCORE_W-1:0]  score;
      logic [DANGER_W-1:0] danger;
      logic [MOVE_W-1:0]   move;
   } item_type;

endpackage

// File: hw/rtl/transposition_table_probe_store_core.sv
`timescale 1ns / 1ps
// Transposition table probe/store core: direct-mapped always-replace search cache.
//
// Each word passes through the core in order: the accepting step captures and masks the
// key, then the index reduction (a reciprocal multiply when TABLE_ENTRIES is below 65536),
// the table read, and the step that evaluates and writes the entry back. The result is
// registered in that update step and the next word can be taken once the core is idle
// again; a result that cannot leave holds the core in the update step. The table is a
// single synchronous RAM of TABLE_ENTRIES entries, so items are processed one at a time
// around that read-modify-write. After reset a clearing pass writes zeros to every entry,
// one per cycle; req_tready stays low during it while csr writes are still taken. A
// finished result waits in the output register while the next word is accepted.
module transposition_table_probe_store_core #(
   parameter int TABLE_ENTRIES = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [ttps_pkg::MASK_W-1:0]       csr_wr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // hash_key, ply, depth, alpha, beta, init_alpha, score, danger, move_word, pad
   input  logic [ttps_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode
   input  logic [ttps_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // bound_value, hash_move, hash_move_score, danger_out, pad
   output logic [ttps_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status, hash_move_valid
   output logic [ttps_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import ttps_pkg::*;

   localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_ENTRIES - 1);

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [MASK_W-1:0]    mask_ff;
   item_type             req_ff;
   logic [MASK_W-1:0]    m_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [ADDR_W-1:0]    idx;
   logic                 rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [ENTRY_W-1:0]   ram_wdata;
   logic                 ram_re;
   logic [ENTRY_W-1:0]   ram_rdata;
   logic                 rsp_load;
   logic                 req_fire;

   table_entry_type      old_e;
   table_entry_type      new_e;
   logic                 item_we;
   status_type           status;
   logic [SCORE_W-1:0]   bound;
   logic                 hm_valid;
   logic [MOVE_W-1:0]    hm_move;
   logic [SCORE_W-1:0]   hm_score;
   logic [DANGER_W-1:0]  hm_danger;
   logic [SCORE_W:0]     v_ext;
   logic [SCORE_W:0]     v_abs;
   logic [PLY_W:0]       ply_m1;
   logic [SCORE_W:0]     v_adj;

   // Index reduction: (key & mask) mod TABLE_ENTRIES.
   generate
      if (TABLE_ENTRIES < 65536) begin : g_mod
         localparam logic [31:0] RECIP =
            32'(((64'd1 << 32) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));
         localparam logic [MASK_W-1:0] N_C = MASK_W'(TABLE_ENTRIES);
         logic [MASK_W+31:0] prod_ff;
         logic [MASK_W-1:0]  quot;
         logic [MASK_W-1:0]  rem;
         always_ff @(posedge clock) begin
            if (state_ff == ST_MAP) begin
               prod_ff <= (MASK_W + 32)'(m_ff) * (MASK_W + 32)'(RECIP);
            end
         end
         assign quot = prod_ff[MASK_W+31:32];
         assign rem  = m_ff - MASK_W'(quot * N_C);
         assign idx  = rem[ADDR_W-1:0];
      end else begin : g_wide
         assign idx = ADDR_W'(m_ff);
      end
   endgenerate

   assign req_fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         mask_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff.mode       <= req_tuser[1:0];
         req_ff.key        <= req_tdata[63:0];
         req_ff.ply        <= req_tdata[70:64];
         req_ff.depth      <= req_tdata[77:71];
         req_ff.alpha      <= req_tdata[93:78];
         req_ff.beta       <= req_tdata[109:94];
         req_ff.init_alpha <= req_tdata[125:110];
         req_ff.score      <= req_tdata[141:126];
         req_ff.danger     <= req_tdata[149:142];
         req_ff.move       <= req_tdata[174:150];
         m_ff              <= req_tdata[MASK_W-1:0] & mask_ff;
      end
      if (state_ff == ST_READ) begin
         addr_ff <= idx;
      end
      if (rsp_load) begin
         rsp_data_ff <= {7'd0, hm_danger, hm_score, hm_move, bound};
         rsp_user_ff <= {hm_valid, status};
      end
   end

   ttps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx),
      .rd_data (ram_rdata)
   );

   // Entry evaluation and update.
   always_comb begin
      old_e     = table_entry_type'(ram_rdata);
      new_e     = old_e;
      item_we   = 1'b0;
      status    = STAT_MISS;
      bound     = '0;
      hm_valid  = 1'b0;
      hm_move   = '0;
      hm_score  = '0;
      hm_danger = '0;
      v_ext     = {old_e.score[SCORE_W-1], old_e.score};
      v_abs     = old_e.score[SCORE_W-1] ? ((SCORE_W + 1)'(0) - v_ext) : v_ext;
      ply_m1    = {1'b0, req_ff.ply} - (PLY_W + 1)'(1);
      if (!old_e.score[SCORE_W-1] && (old_e.score != '0)) begin
         v_adj = v_ext - {{(SCORE_W - PLY_W){ply_m1[PLY_W]}}, ply_m1};
      end else begin
         v_adj = v_ext + {{(SCORE_W - PLY_W){ply_m1[PLY_W]}}, ply_m1};
      end
      unique case (req_ff.mode)
         MODE_LOOKUP: begin
            if ((old_e.key == req_ff.key) && (old_e.depth >= req_ff.depth)) begin
               hm_valid  = 1'b1;
               hm_move   = old_e.move;
               hm_score  = old_e.score;
               hm_danger = old_e.danger;
               unique case (old_e.kind)
                  KIND_EXACT: begin
                     status = STAT_EXACT;
                     bound  = (v_abs >= MATE_NEAR) ? v_adj[SCORE_W-1:0] : old_e.score;
                  end
                  KIND_UPPER: begin
                     if ($signed(old_e.score) <= $signed(req_ff.alpha)) begin
                        status = STAT_UPPER;
                        bound  = old_e.score;
                     end
                  end
                  KIND_LOWER: begin
                     if ($signed(old_e.score) >= $signed(req_ff.beta)) begin
                        status = STAT_LOWER;
                        bound  = old_e.score;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         MODE_REFUTE: begin
            item_we      = 1'b1;
            status       = STAT_STORED;
            new_e.key    = req_ff.key;
            new_e.score  = req_ff.score;
            new_e.depth  = req_ff.depth;
            new_e.kind   = KIND_LOWER;
            new_e.danger = req_ff.danger;
            new_e.move   = req_ff.move;
         end
         MODE_BEST: begin
            item_we     = 1'b1;
            status      = STAT_STORED;
            new_e.key   = req_ff.key;
            new_e.score = req_ff.alpha;
            new_e.depth = req_ff.depth;
            if ($signed(req_ff.alpha) > $signed(req_ff.init_alpha)) begin
               new_e.kind = KIND_EXACT;
               new_e.move = {old_e.move[MOVE_W-1:MOVE_LO_W], req_ff.move[MOVE_LO_W-1:0]};
            end else begin
               new_e.kind = KIND_UPPER;
               new_e.move = {old_e.move[MOVE_W-1:MOVE_LO_W], {MOVE_LO_W{1'b0}}};
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      req_tready = 1'b0;
      ram_re     = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = addr_ff;
      ram_wdata  = new_e;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            ram_re   = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ram_we   = item_we;
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("word accepted during table clear");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == ST_EXEC) || (state_ff == ST_CLEAR)))
      else $error("table written outside clear or update");

   a_accept_to_map: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_MAP))
      else $error("accepted word did not start index mapping");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (32'(idx) < 32'(TABLE_ENTRIES)))
      else $error("table index out of range");

   a_stored_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_user_ff[2:0] == STAT_STORED))
         |-> ((rsp_data_ff == '0) && !rsp_user_ff[3]))
      else $error("store result carries payload");
`endif

endmodule

// File: hw/rtl/ttps_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module ttps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: tb/transposition_table_probe_store_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the transposition table probe/store core.
module transposition_table_probe_store_core_tb;
   import ttps_pkg::*;

   localparam int TABLE_SIZE = 65536;
   localparam int KEY_POOL = 24;
   localparam int STALL_LIMIT = 262144;
   localparam int RANDOM_PER_MASK = 256;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      status_type        status;
      logic [SCORE_W-1:0] bound;
      logic              hit;
      logic [MOVE_W-1:0] move;
      logic [SCORE_W-1:0] move_score;
      logic [DANGER_W-1:0] danger;
   } probe_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [MASK_W-1:0]     csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   item_type              words_pending[$];
   probe_result_type      probe_results_due[$];
   table_entry_type       tt_shadow[int unsigned];
   logic [MASK_W-1:0]     index_mask_shadow = 16'hFFFF;
   logic [KEY_W-1:0]      key_pool[KEY_POOL];
   item_type              offered;
   int                    items_queued = 0;
   int                    items_taken = 0;
   int                    fail_count = 0;
   int                    burst_left = 0;
   int                    gap_left = 0;
   int                    stall_phase = 0;
   int                    quiet_cycles = 0;

   transposition_table_probe_store_core dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic probe_result_type probe_or_store(item_type w);
      probe_result_type r;
      table_entry_type e;
      int unsigned slot;
      int v;
      int mag;
      r = '0;
      slot = int'(w.key[MASK_W-1:0] & index_mask_shadow) % TABLE_SIZE;
      e = '0;
      if (tt_shadow.exists(slot)) e = tt_shadow[slot];
      case (w.mode)
         MODE_LOOKUP: begin
            if (e.key == w.key && e.depth >= w.depth) begin
               v = $signed(e.score);
               r.hit = 1'b1;
               r.move = e.move;
               r.move_score = e.score;
               r.danger = e.danger;
               case (e.kind)
                  KIND_EXACT: begin
                     mag = (v < 0) ? -v : v;
                     if (mag >= MATE_SCORE - 100) begin
                        if (v > 0) v = v - (int'(w.ply) - 1);
                        else v = v + (int'(w.ply) - 1);
                     end
                     r.status = STAT_EXACT;
                     r.bound = v[SCORE_W-1:0];
                  end
                  KIND_UPPER: begin
                     if (v <= $signed(w.alpha)) begin
                        r.status = STAT_UPPER;
                        r.bound = e.score;
                     end
                  end
                  KIND_LOWER: begin
                     if (v >= $signed(w.beta)) begin
                        r.status = STAT_LOWER;
                        r.bound = e.score;
                     end
                  end
                  default: ;
               endcase
            end
         end
         MODE_REFUTE: begin
            e.key = w.key;
            e.score = w.score;
            e.kind = KIND_LOWER;
            e.danger = w.danger;
            e.move = w.move;
            e.depth = w.depth;
            tt_shadow[slot] = e;
            r.status = STAT_STORED;
         end
         MODE_BEST: begin
            e.key = w.key;
            e.depth = w.depth;
            if ($signed(w.alpha) > $signed(w.init_alpha)) begin
               e.move = {e.move[MOVE_W-1:MOVE_LO_W], w.move[MOVE_LO_W-1:0]};
               e.kind = KIND_EXACT;
            end else begin
               e.move = {e.move[MOVE_W-1:MOVE_LO_W], {MOVE_LO_W{1'b0}}};
               e.kind = KIND_UPPER;
            end
            e.score = w.alpha;
            tt_shadow[slot] = e;
            r.status = STAT_STORED;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic item_type compose_word(logic [1:0] mode, logic [KEY_W-1:0] key,
                                             int ply, int depth, int alpha, int beta,
                                             int init_alpha, int score, int danger,
                                             int mv);
      item_type w;
      w.mode = mode;
      w.key = key;
      w.ply = PLY_W'(ply);
      w.depth = DEPTH_W'(depth);
      w.alpha = SCORE_W'(alpha);
      w.beta = SCORE_W'(beta);
      w.init_alpha = SCORE_W'(init_alpha);
      w.score = SCORE_W'(score);
      w.danger = DANGER_W'(danger);
      w.move = MOVE_W'(mv);
      return w;
   endfunction

   // half of the picks are mate-range or extreme scores, so the adjustment and compares get exercised
   function automatic logic [SCORE_W-1:0] pick_score();
      int r;
      r = $urandom_range(0, 7);
      case (r)
         3: return SCORE_W'(MATE_SCORE - 100 + $urandom_range(0, 2867));
         4: return SCORE_W'(-(MATE_SCORE - 100 + $urandom_range(0, 2868)));
         5: return 16'h8000;
         6: return 16'h7FFF;
         7: return SCORE_W'(int'($urandom_range(0, 200)) - 100);
         default: return SCORE_W'($urandom);
      endcase
   endfunction

   function automatic item_type random_word();
      item_type w;
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) w.mode = MODE_LOOKUP;
      else if (r < 70) w.mode = MODE_REFUTE;
      else if (r < 95) w.mode = MODE_BEST;
      else w.mode = MODE_UNUSED;
      if ($urandom_range(0, 4) == 0) w.key = {$urandom, $urandom};
      else w.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      w.ply = PLY_W'($urandom);
      w.depth = DEPTH_W'($urandom);
      w.alpha = pick_score();
      w.beta = pick_score();
      w.init_alpha = pick_score();
      w.score = pick_score();
      w.danger = DANGER_W'($urandom);
      w.move = MOVE_W'($urandom);
      return w;
   endfunction

   task automatic queue_word(item_type w);
      words_pending.push_back(w);
      items_queued++;
   endtask

   task automatic drain_table();
      while (!(items_taken == items_queued && probe_results_due.size() == 0))
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_index_mask(logic [MASK_W-1:0] mask);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mask;
      index_mask_shadow = mask;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // word source: bursts of random length with random gaps
   always @(posedge clock) begin : drive_requests
      logic next_valid;
      next_valid = req_tvalid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            probe_results_due.push_back(probe_or_store(offered));
            items_taken++;
         end
         if (!req_tvalid || req_tready) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (words_pending.size() > 0) begin
               offered = words_pending.pop_front();
               next_valid = 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  if ($urandom_range(0, 3) == 0) begin
                     burst_left = 40;
                     gap_left = 0;
                  end else begin
                     burst_left = $urandom_range(1, 12);
                     gap_left = $urandom_range(1, 7);
                  end
               end
            end
         end
      end
      req_tvalid <= next_valid;
      if (next_valid) begin
         req_tdata <= {1'b0, offered.move, offered.danger, offered.score, offered.init_alpha,
                       offered.beta, offered.alpha, offered.depth, offered.ply, offered.key};
         req_tuser <= offered.mode;
      end
   end

   always @(posedge clock) begin : check_responses
      probe_result_type got;
      probe_result_type want;
      logic ready_next;
      ready_next = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tuser[2:0]);
            got.hit = rsp_tuser[3];
            got.bound = rsp_tdata[15:0];
            got.move = rsp_tdata[40:16];
            got.move_score = rsp_tdata[56:41];
            got.danger = rsp_tdata[64:57];
            if (probe_results_due.size() == 0) begin
               $error("result word with nothing expected: status %0d", got.status);
               fail_count++;
            end else begin
               want = probe_results_due.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.bound !== want.bound) begin
                  $error("bound_value: expected %0d, got %0d",
                         $signed(want.bound), $signed(got.bound));
                  fail_count++;
               end
               if (got.hit !== want.hit) begin
                  $error("hash_move_valid: expected %0d, got %0d", want.hit, got.hit);
                  fail_count++;
               end
               if (got.move !== want.move) begin
                  $error("hash_move: expected %h, got %h", want.move, got.move);
                  fail_count++;
               end
               if (got.move_score !== want.move_score) begin
                  $error("hash_move_score: expected %0d, got %0d",
                         $signed(want.move_score), $signed(got.move_score));
                  fail_count++;
               end
               if (got.danger !== want.danger) begin
                  $error("danger_out: expected %0d, got %0d", want.danger, got.danger);
                  fail_count++;
               end
            end
         end
         stall_phase++;
         case ((stall_phase / 300) % 4)
            0: ready_next = 1'b1;
            1: ready_next = $urandom_range(0, 1);
            2: ready_next = (stall_phase % 4 == 0);
            default: ready_next = ($urandom_range(0, 4) != 0);
         endcase
      end
      rsp_tready <= ready_next;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("** transposition_table_probe_store_core: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      logic [MASK_W-1:0] mask_steps[6];
      logic [KEY_W-1:0] ka, kb, kc, kd, ke, kf, kg;
      mask_steps = '{16'hFFFF, 16'h0000, 16'h000F, 16'h5A3C, 16'h00FF, 16'hFFFF};
      ka = 64'hFFFF_FFFF_FFFF_FFFF;
      kb = 64'h8000_0000_0000_1234;
      kc = 64'h0123_4567_89AB_0003;
      kd = 64'h7FFF_0000_FFFF_0104;
      ke = 64'h0000_0001_0000_0205;
      kf = 64'hDEAD_BEEF_0000_0306;
      kg = 64'h5555_AAAA_5555_0407;
      for (int i = 0; i < KEY_POOL; i++) begin
         if (i == 0) key_pool[i] = '0;
         else if (i == 1) key_pool[i] = '1;
         else if (i % 3 == 2) key_pool[i] = {~key_pool[i-1][KEY_W-1:16], key_pool[i-1][15:0]};
         else key_pool[i] = {$urandom, $urandom};
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_index_mask(16'hFFFF);

      // empty entry at key zero matches, then depth and key misses
      queue_word(compose_word(MODE_LOOKUP, '0, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_word(compose_word(MODE_LOOKUP, '0, 0, 1, 0, 0, 0, 0, 0, 0));
      queue_word(compose_word(MODE_LOOKUP, ka, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_word(compose_word(MODE_REFUTE, ka, 0, 127, 0, 0, 0, -32768, 255, 'h1FFFFFF));
      queue_word(compose_word(MODE_LOOKUP, ka, 127, 127, 0, -32768, 0, 0, 0, 0));
      // best keeps en passant, promotion and danger of the old entry
      queue_word(compose_word(MODE_BEST, ka, 0, 10, 29950, 0, -32768, 0, 0, 0));
      queue_word(compose_word(MODE_LOOKUP, ka, 0, 10, 0, 0, 0, 0, 0, 0));
      queue_word(compose_word(MODE_LOOKUP, ka, 127, 0, 0, 0, 0, 0, 0, 0));
      queue_word(compose_word(MODE_BEST, kb, 0, 0, 32767, 0, 0, 0, 0, 'h0ABCDE));
      queue_word(compose_word(MODE_LOOKUP, kb, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_word(compose_word(MODE_BEST, kc, 0, 127, -32767, 0, -32768, 0, 0, 'h1F0F0F0));
      queue_word(compose_word(MODE_LOOKUP, kc, 0, 127, 0, 0, 0, 0, 0, 0));
      queue_word(compose_word(MODE_LOOKUP, kc, 127, 0, 0, 0, 0, 0, 0, 0));
      // alpha equal to initial alpha stores an upper bound
      queue_word(compose_word(MODE_BEST, kd, 0, 5, 100, 0, 100, 0, 0, 'h1FFFFFF));
      queue_word(compose_word(MODE_LOOKUP, kd, 0, 5, 100, 0, 0, 0, 0, 0));
      queue_word(compose_word(MODE_LOOKUP, kd, 0, 5, 99, 0, 0, 0, 0, 0));
      queue_word(compose_word(MODE_BEST, ke, 0, 1, -32768, 0, -32768, 0, 0, 0));
      queue_word(compose_word(MODE_LOOKUP, ke, 0, 1, -32768, 0, 0, 0, 0, 0));
      queue_word(compose_word(MODE_BEST, kf, 0, 3, 29899, 0, 0, 0, 0, 'h12345));
      queue_word(compose_word(MODE_LOOKUP, kf, 50, 3, 0, 0, 0, 0, 0, 0));
      queue_word(compose_word(MODE_BEST, kg, 0, 3, -29900, 0, -32768, 0, 0, 'h54321));
      queue_word(compose_word(MODE_LOOKUP, kg, 5, 3, 0, 0, 0, 0, 0, 0));
      queue_word(compose_word(MODE_UNUSED, ka, 127, 127, -1, -1, -1, -1, 255, 'h1FFFFFF));
      queue_word(compose_word(MODE_LOOKUP, ka, 1, 0, 0, 0, 0, 0, 0, 0));
      queue_word(compose_word(MODE_REFUTE, kd, 0, 9, 0, 0, 0, 50, 7, 'h0000FFF));
      queue_word(compose_word(MODE_LOOKUP, kd, 0, 9, 0, 51, 0, 0, 0, 0));
      drain_table();

      foreach (mask_steps[m]) begin
         write_index_mask(mask_steps[m]);
         for (int i = 0; i < RANDOM_PER_MASK / 2; i++) queue_word(random_word());
         // hold the source until the table has answered everything
         drain_table();
         for (int i = 0; i < RANDOM_PER_MASK / 2; i++) queue_word(random_word());
         drain_table();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0 && probe_results_due.size() == 0)
         $display("** transposition_table_probe_store_core: PASSED **");
      else
         $display("** transposition_table_probe_store_core: FAILED **");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/ttps_pkg.sv
hw/rtl/ttps_ram.sv
hw/rtl/transposition_table_probe_store_core.sv
tb/transposition_table_probe_store_core_tb.sv
